// ===== design/assert_macros.svh =====
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is low
`define PGV_ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("pgv assertion failed");

// clocked property, also checked during reset
`define PGV_ASSERT_ALL(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("pgv assertion failed");

`endif

// ===== design/pgv_pkg.sv =====
// shared types, constants and microcode for the particle verlet update block
// no dependencies
`default_nettype none

package pgv_pkg;

    localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;
    localparam logic [31:0] FP_HALF = 32'h3F00_0000;
    localparam int          PC_W    = 6;

    typedef enum logic [2:0] {
        FOP_ADD,
        FOP_SUB,
        FOP_MUL,
        FOP_DIV,
        FOP_SQRT
    } fop_t;

    typedef enum logic [1:0] {
        ACT_LOAD,
        ACT_FORCE,
        ACT_UPD_POS,
        ACT_UPD_VEL
    } action_t;

    typedef enum logic [4:0] {
        OPD_POS0, OPD_POS1, OPD_POS2,
        OPD_VEL0, OPD_VEL1, OPD_VEL2,
        OPD_FS0,  OPD_FS1,  OPD_FS2,
        OPD_PF0,  OPD_PF1,  OPD_PF2,
        OPD_IN0,  OPD_IN1,  OPD_IN2,
        OPD_MJ,   OPD_DT,   OPD_MASS, OPD_HALF,
        OPD_D0,   OPD_D1,   OPD_D2,
        OPD_R,    OPD_T,    OPD_NUM,  OPD_DEN, OPD_F, OPD_A
    } opnd_t;

    typedef struct packed {
        fop_t  op;
        opnd_t src_a;
        opnd_t src_b;
        opnd_t dst;
        logic  zchk;
        logic  last;
    } uop_t;

    typedef struct packed {
        logic        start;
        fop_t        op;
        logic [31:0] a;
        logic [31:0] b;
    } fpu_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } fpu_rsp_t;

    localparam logic [PC_W-1:0] PC_FORCE   = 6'd0;
    localparam logic [PC_W-1:0] PC_UPD_POS = 6'd18;
    localparam logic [PC_W-1:0] PC_UPD_VEL = 6'd32;

    function automatic uop_t mk(input fop_t op, input opnd_t a, input opnd_t b,
                                input opnd_t d, input logic z, input logic l);
        uop_t u;
        u.op    = op;
        u.src_a = a;
        u.src_b = b;
        u.dst   = d;
        u.zchk  = z;
        u.last  = l;
        return u;
    endfunction

    function automatic uop_t ucode(input logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            // partner force
            6'd0:  u = mk(FOP_SUB,  OPD_IN0,  OPD_POS0, OPD_D0,  1'b0, 1'b0);
            6'd1:  u = mk(FOP_SUB,  OPD_IN1,  OPD_POS1, OPD_D1,  1'b0, 1'b0);
            6'd2:  u = mk(FOP_SUB,  OPD_IN2,  OPD_POS2, OPD_D2,  1'b0, 1'b0);
            6'd3:  u = mk(FOP_MUL,  OPD_D0,   OPD_D0,   OPD_R,   1'b0, 1'b0);
            6'd4:  u = mk(FOP_MUL,  OPD_D1,   OPD_D1,   OPD_T,   1'b0, 1'b0);
            6'd5:  u = mk(FOP_ADD,  OPD_R,    OPD_T,    OPD_R,   1'b0, 1'b0);
            6'd6:  u = mk(FOP_MUL,  OPD_D2,   OPD_D2,   OPD_T,   1'b0, 1'b0);
            6'd7:  u = mk(FOP_ADD,  OPD_R,    OPD_T,    OPD_R,   1'b1, 1'b0);
            6'd8:  u = mk(FOP_MUL,  OPD_MASS, OPD_MJ,   OPD_NUM, 1'b0, 1'b0);
            6'd9:  u = mk(FOP_SQRT, OPD_R,    OPD_R,    OPD_DEN, 1'b0, 1'b0);
            6'd10: u = mk(FOP_MUL,  OPD_DEN,  OPD_R,    OPD_DEN, 1'b0, 1'b0);
            6'd11: u = mk(FOP_DIV,  OPD_NUM,  OPD_DEN,  OPD_F,   1'b0, 1'b0);
            6'd12: u = mk(FOP_MUL,  OPD_F,    OPD_D0,   OPD_T,   1'b0, 1'b0);
            6'd13: u = mk(FOP_ADD,  OPD_FS0,  OPD_T,    OPD_FS0, 1'b0, 1'b0);
            6'd14: u = mk(FOP_MUL,  OPD_F,    OPD_D1,   OPD_T,   1'b0, 1'b0);
            6'd15: u = mk(FOP_ADD,  OPD_FS1,  OPD_T,    OPD_FS1, 1'b0, 1'b0);
            6'd16: u = mk(FOP_MUL,  OPD_F,    OPD_D2,   OPD_T,   1'b0, 1'b0);
            6'd17: u = mk(FOP_ADD,  OPD_FS2,  OPD_T,    OPD_FS2, 1'b0, 1'b1);
            // position half step
            6'd18: u = mk(FOP_MUL,  OPD_DT,   OPD_HALF, OPD_A,   1'b0, 1'b0);
            6'd19: u = mk(FOP_DIV,  OPD_A,    OPD_MASS, OPD_A,   1'b0, 1'b0);
            6'd20: u = mk(FOP_MUL,  OPD_A,    OPD_FS0,  OPD_T,   1'b0, 1'b0);
            6'd21: u = mk(FOP_ADD,  OPD_VEL0, OPD_T,    OPD_T,   1'b0, 1'b0);
            6'd22: u = mk(FOP_MUL,  OPD_DT,   OPD_T,    OPD_T,   1'b0, 1'b0);
            6'd23: u = mk(FOP_ADD,  OPD_POS0, OPD_T,    OPD_POS0, 1'b0, 1'b0);
            6'd24: u = mk(FOP_MUL,  OPD_A,    OPD_FS1,  OPD_T,   1'b0, 1'b0);
            6'd25: u = mk(FOP_ADD,  OPD_VEL1, OPD_T,    OPD_T,   1'b0, 1'b0);
            6'd26: u = mk(FOP_MUL,  OPD_DT,   OPD_T,    OPD_T,   1'b0, 1'b0);
            6'd27: u = mk(FOP_ADD,  OPD_POS1, OPD_T,    OPD_POS1, 1'b0, 1'b0);
            6'd28: u = mk(FOP_MUL,  OPD_A,    OPD_FS2,  OPD_T,   1'b0, 1'b0);
            6'd29: u = mk(FOP_ADD,  OPD_VEL2, OPD_T,    OPD_T,   1'b0, 1'b0);
            6'd30: u = mk(FOP_MUL,  OPD_DT,   OPD_T,    OPD_T,   1'b0, 1'b0);
            6'd31: u = mk(FOP_ADD,  OPD_POS2, OPD_T,    OPD_POS2, 1'b0, 1'b1);
            // velocity half step
            6'd32: u = mk(FOP_MUL,  OPD_DT,   OPD_HALF, OPD_A,   1'b0, 1'b0);
            6'd33: u = mk(FOP_DIV,  OPD_A,    OPD_MASS, OPD_A,   1'b0, 1'b0);
            6'd34: u = mk(FOP_ADD,  OPD_FS0,  OPD_PF0,  OPD_T,   1'b0, 1'b0);
            6'd35: u = mk(FOP_MUL,  OPD_A,    OPD_T,    OPD_T,   1'b0, 1'b0);
            6'd36: u = mk(FOP_ADD,  OPD_VEL0, OPD_T,    OPD_VEL0, 1'b0, 1'b0);
            6'd37: u = mk(FOP_ADD,  OPD_FS1,  OPD_PF1,  OPD_T,   1'b0, 1'b0);
            6'd38: u = mk(FOP_MUL,  OPD_A,    OPD_T,    OPD_T,   1'b0, 1'b0);
            6'd39: u = mk(FOP_ADD,  OPD_VEL1, OPD_T,    OPD_VEL1, 1'b0, 1'b0);
            6'd40: u = mk(FOP_ADD,  OPD_FS2,  OPD_PF2,  OPD_T,   1'b0, 1'b0);
            6'd41: u = mk(FOP_MUL,  OPD_A,    OPD_T,    OPD_T,   1'b0, 1'b0);
            6'd42: u = mk(FOP_ADD,  OPD_VEL2, OPD_T,    OPD_VEL2, 1'b0, 1'b1);
            default: u = mk(FOP_ADD, OPD_T,   OPD_T,    OPD_T,   1'b0, 1'b1);
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

// ===== design/pgv_fpu.sv =====
// shared single precision unit: add, subtract, multiply, divide, square root
// round to nearest even with subnormals; depends on pgv_pkg
`default_nettype none

module pgv_fpu import pgv_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire fpu_req_t req,
    output fpu_rsp_t      rsp
);

    typedef enum logic [2:0] {F_IDLE, F_UNPK, F_CORE, F_ITER, F_NORM, F_RND} fst_t;

    typedef struct packed {
        logic               sgn;
        logic signed [11:0] e;
        logic [23:0]        m;
        logic               nan;
        logic               inf;
        logic               zero;
    } unpk_t;

    function automatic unpk_t unpack(input logic [31:0] x);
        unpk_t u;
        logic [4:0] lz;
        lz     = 5'd0;
        u.sgn  = x[31];
        u.nan  = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
        u.inf  = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
        u.zero = (x[30:0] == 31'd0);
        for (int i = 0; i < 23; i++) begin
            if (x[i]) lz = 5'(23 - i);
        end
        if (x[30:23] == 8'd0) begin
            u.m = {1'b0, x[22:0]} << lz;
            u.e = -12'sd126 - $signed({7'd0, lz});
        end else begin
            u.m = {1'b1, x[22:0]};
            u.e = $signed({4'd0, x[30:23]}) - 12'sd127;
        end
        return u;
    endfunction

    function automatic logic [31:0] round_pack(input logic sgn, input logic signed [11:0] e,
                                               input logic [49:0] m, input logic st);
        logic [63:0] w;
        logic [63:0] kept;
        logic [63:0] rsh;
        logic [11:0] ex;
        logic [5:0]  sh;
        logic        rb;
        logic        stk;
        logic        inc;
        logic [7:0]  be;
        logic [30:0] base;
        w = {14'd0, m};
        if (e >= -12'sd126) ex = 12'd0;
        else                ex = 12'(-12'sd126 - e);
        if (ex > 12'd34) sh = 6'd60;
        else             sh = 6'd26 + ex[5:0];
        kept = w >> sh;
        rsh  = w >> (sh - 6'd1);
        rb   = rsh[0];
        stk  = st | ((w & ((64'd1 << (sh - 6'd1)) - 64'd1)) != 64'd0);
        inc  = rb & (stk | kept[0]);
        be   = 8'(e + 12'sd127);
        if (e >= -12'sd126) base = {be, kept[22:0]};
        else                base = {8'd0, kept[22:0]};
        if (e > 12'sd127) return {sgn, 8'hFF, 23'd0};
        return {sgn, base + 31'(inc)};
    endfunction

    fst_t               st_reg, st_next;
    fop_t               op_reg, op_next;
    logic [31:0]        a_reg, a_next, b_reg, b_next;
    logic               sa_reg, sa_next, sb_reg, sb_next;
    logic signed [11:0] ea_reg, ea_next, eb_reg, eb_next;
    logic [23:0]        ma_reg, ma_next, mb_reg, mb_next;
    logic               spec_reg, spec_next;
    logic [31:0]        sval_reg, sval_next;
    logic               sgn_reg, sgn_next;
    logic signed [11:0] exp_reg, exp_next;
    logic [50:0]        sum_reg, sum_next;
    logic [49:0]        man_reg, man_next;
    logic               stk_reg, stk_next;
    logic [25:0]        rem_reg, rem_next;
    logic [26:0]        q_reg, q_next;
    logic [55:0]        n_reg, n_next, res_reg, res_next, bit_reg, bit_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic [31:0]        out_reg, out_next;

    unpk_t              ua, ub;
    logic               sbe;
    logic               a_big;
    logic [23:0]        m_big, m_sml;
    logic signed [11:0] e_big, e_sml;
    logic [11:0]        dexp;
    logic [50:0]        lrg, sml0, sml;
    logic               sml_st;
    logic [47:0]        prod;
    logic [25:0]        rem_sub;
    logic               ge;
    logic [55:0]        trial;
    logic [5:0]         lz;

    always_comb begin
        st_next   = st_reg;
        op_next   = op_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        sa_next   = sa_reg;
        sb_next   = sb_reg;
        ea_next   = ea_reg;
        eb_next   = eb_reg;
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        spec_next = spec_reg;
        sval_next = sval_reg;
        sgn_next  = sgn_reg;
        exp_next  = exp_reg;
        sum_next  = sum_reg;
        man_next  = man_reg;
        stk_next  = stk_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        n_next    = n_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        out_next  = out_reg;

        ua    = unpack(a_reg);
        ub    = unpack(b_reg);
        sbe   = ub.sgn ^ (op_reg == FOP_SUB);
        a_big = (ea_reg > eb_reg) || ((ea_reg == eb_reg) && (ma_reg >= mb_reg));
        m_big = a_big ? ma_reg : mb_reg;
        m_sml = a_big ? mb_reg : ma_reg;
        e_big = a_big ? ea_reg : eb_reg;
        e_sml = a_big ? eb_reg : ea_reg;
        dexp  = 12'(e_big - e_sml);
        lrg   = {1'b0, m_big, 26'd0};
        sml0  = {1'b0, m_sml, 26'd0};
        if (dexp > 12'd50) begin
            sml    = 51'd0;
            sml_st = 1'b1;
        end else begin
            sml    = sml0 >> dexp[5:0];
            sml_st = (sml0 & ((51'd1 << dexp[5:0]) - 51'd1)) != 51'd0;
        end
        sml[0] = sml[0] | sml_st;
        prod   = ma_reg * mb_reg;
        ge      = rem_reg >= {2'd0, mb_reg};
        rem_sub = ge ? rem_reg - {2'd0, mb_reg} : rem_reg;
        trial   = res_reg + bit_reg;
        lz = 6'd0;
        for (int i = 0; i < 50; i++) begin
            if (sum_reg[i]) lz = 6'(49 - i);
        end

        case (st_reg)
            F_IDLE: begin
                if (req.start) begin
                    op_next = req.op;
                    a_next  = req.a;
                    b_next  = req.b;
                    st_next = F_UNPK;
                end
            end
            F_UNPK: begin
                sa_next   = ua.sgn;
                sb_next   = sbe;
                ea_next   = ua.e;
                eb_next   = ub.e;
                ma_next   = ua.m;
                mb_next   = ub.m;
                spec_next = 1'b1;
                sval_next = FP_QNAN;
                case (op_reg)
                    FOP_ADD, FOP_SUB: begin
                        if (ua.nan || ub.nan)        sval_next = FP_QNAN;
                        else if (ua.inf && ub.inf)
                            sval_next = (ua.sgn != sbe) ? FP_QNAN : {ua.sgn, 8'hFF, 23'd0};
                        else if (ua.inf)             sval_next = {ua.sgn, 8'hFF, 23'd0};
                        else if (ub.inf)             sval_next = {sbe, 8'hFF, 23'd0};
                        else if (ua.zero && ub.zero) sval_next = {ua.sgn & sbe, 31'd0};
                        else if (ua.zero)            sval_next = {sbe, b_reg[30:0]};
                        else if (ub.zero)            sval_next = a_reg;
                        else                         spec_next = 1'b0;
                    end
                    FOP_MUL: begin
                        if (ua.nan || ub.nan)                           sval_next = FP_QNAN;
                        else if ((ua.inf && ub.zero) || (ub.inf && ua.zero))
                            sval_next = FP_QNAN;
                        else if (ua.inf || ub.inf)
                            sval_next = {ua.sgn ^ ub.sgn, 8'hFF, 23'd0};
                        else if (ua.zero || ub.zero) sval_next = {ua.sgn ^ ub.sgn, 31'd0};
                        else                         spec_next = 1'b0;
                    end
                    FOP_DIV: begin
                        if (ua.nan || ub.nan)        sval_next = FP_QNAN;
                        else if (ub.zero)
                            sval_next = ua.zero ? FP_QNAN : {ua.sgn ^ ub.sgn, 8'hFF, 23'd0};
                        else if (ua.inf && ub.inf)   sval_next = FP_QNAN;
                        else if (ua.inf)             sval_next = {ua.sgn ^ ub.sgn, 8'hFF, 23'd0};
                        else if (ub.inf || ua.zero)  sval_next = {ua.sgn ^ ub.sgn, 31'd0};
                        else                         spec_next = 1'b0;
                    end
                    FOP_SQRT: begin
                        if (ua.nan)                  sval_next = FP_QNAN;
                        else if (ua.zero)            sval_next = a_reg;
                        else if (ua.sgn)             sval_next = FP_QNAN;
                        else if (ua.inf)             sval_next = a_reg;
                        else                         spec_next = 1'b0;
                    end
                    default: sval_next = FP_QNAN;
                endcase
                st_next = F_CORE;
            end
            F_CORE: begin
                stk_next = 1'b0;
                cnt_next = 5'd0;
                if (spec_reg) begin
                    st_next = F_RND;
                end else begin
                    case (op_reg)
                        FOP_MUL: begin
                            sum_next = {prod, 3'd0};
                            exp_next = ea_reg + eb_reg;
                            sgn_next = sa_reg ^ sb_reg;
                            st_next  = F_NORM;
                        end
                        FOP_DIV: begin
                            rem_next = {2'd0, ma_reg};
                            q_next   = 27'd0;
                            exp_next = ea_reg - eb_reg;
                            sgn_next = sa_reg ^ sb_reg;
                            st_next  = F_ITER;
                        end
                        FOP_SQRT: begin
                            if (ea_reg[0]) begin
                                n_next   = {2'd0, ma_reg, 1'b0, 29'd0};
                                exp_next = (ea_reg - 12'sd1) >>> 1;
                            end else begin
                                n_next   = {3'd0, ma_reg, 29'd0};
                                exp_next = ea_reg >>> 1;
                            end
                            res_next = 56'd0;
                            bit_next = 56'd1 << 52;
                            sgn_next = 1'b0;
                            st_next  = F_ITER;
                        end
                        default: begin
                            sum_next = (sa_reg != sb_reg) ? lrg - sml : lrg + sml;
                            exp_next = e_big;
                            sgn_next = a_big ? sa_reg : sb_reg;
                            st_next  = F_NORM;
                        end
                    endcase
                end
            end
            F_ITER: begin
                cnt_next = cnt_reg + 5'd1;
                if (op_reg == FOP_DIV) begin
                    rem_next = rem_sub << 1;
                    q_next   = {q_reg[25:0], ge};
                    if (cnt_reg == 5'd26) begin
                        sum_next = {1'b0, q_reg[25:0], ge, 23'd0};
                        stk_next = rem_sub != 26'd0;
                        st_next  = F_NORM;
                    end
                end else begin
                    if (n_reg >= trial) begin
                        n_next   = n_reg - trial;
                        res_next = (res_reg >> 1) + bit_reg;
                    end else begin
                        res_next = res_reg >> 1;
                    end
                    bit_next = bit_reg >> 2;
                    if (cnt_reg == 5'd26) begin
                        sum_next = {1'b0, res_next[26:0], 23'd0};
                        stk_next = n_next != 56'd0;
                        st_next  = F_NORM;
                    end
                end
            end
            F_NORM: begin
                if (sum_reg[50]) begin
                    man_next = sum_reg[50:1];
                    stk_next = stk_reg | sum_reg[0];
                    exp_next = exp_reg + 12'sd1;
                end else if (sum_reg == 51'd0) begin
                    spec_next = 1'b1;
                    sval_next = 32'd0;
                end else begin
                    man_next = sum_reg[49:0] << lz;
                    exp_next = exp_reg - $signed({6'd0, lz});
                end
                st_next = F_RND;
            end
            F_RND: begin
                out_next  = spec_reg ? sval_reg : round_pack(sgn_reg, exp_reg, man_reg, stk_reg);
                done_next = 1'b1;
                st_next   = F_IDLE;
            end
            default: st_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= F_IDLE;
            done_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
        op_reg   <= op_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        sa_reg   <= sa_next;
        sb_reg   <= sb_next;
        ea_reg   <= ea_next;
        eb_reg   <= eb_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        spec_reg <= spec_next;
        sval_reg <= sval_next;
        sgn_reg  <= sgn_next;
        exp_reg  <= exp_next;
        sum_reg  <= sum_next;
        man_reg  <= man_next;
        stk_reg  <= stk_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        n_reg    <= n_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        cnt_reg  <= cnt_next;
        out_reg  <= out_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = out_reg;

endmodule

`default_nettype wire

// ===== design/particle_gravity_verlet_update.sv =====
// particle verlet update: sequencer, particle state and stream ports
// depends on pgv_pkg and pgv_fpu
//
// one particle in single precision. requests arrive on the s_ channel with
// the action in s_tuser; each request returns one result on the m_ channel
// with position, velocity and force sum in m_tdata and the coincident flag
// in m_tuser. particle_mass is written through cfg_wen / cfg_wdata.
// load is written straight into the state and passes through the finish state
// to the output register. the other actions run a microcoded sequence on one
// shared float unit, each operation going through issue, the unit and
// write-back; divide and square root iterate inside the unit. force is 18
// operations, ending early when the partner coincides, position step 14,
// velocity step 11, each then passing the finish state to the output register.
// s_tready is high only between requests.
// a finished result waits in the output register; while m_tready is low
// the next request may still be taken and run, and its result is held back
// until the register frees. reset clears the state to +0 and mass to 0.
`default_nettype none

module particle_gravity_verlet_update import pgv_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, partner_mass, time_step
    input  wire logic [255:0] s_tdata,
    // action
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_pos_x/y/z, out_vel_x/y/z, out_force_x/y/z
    output logic [287:0]      m_tdata,
    // coincident
    output logic              m_tuser,
    input  wire logic         cfg_wen,
    input  wire logic [31:0]  cfg_wdata
);

    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_FINISH} st_t;

    st_t              st_reg;
    logic [PC_W-1:0]  pc_reg;
    action_t          act_reg;
    logic             flag_reg;
    logic [31:0]      mass_reg;
    logic [31:0]      pos_reg [3];
    logic [31:0]      vel_reg [3];
    logic [31:0]      fs_reg  [3];
    logic [31:0]      pf_reg  [3];
    logic [31:0]      in_reg  [3];
    logic [31:0]      d_reg   [3];
    logic [31:0]      mj_reg, dt_reg, r_reg, t_reg, num_reg, den_reg, f_reg, a_reg;
    logic             m_valid_reg;
    logic [287:0]     m_data_reg;
    logic             m_user_reg;

    uop_t             uop;
    fpu_req_t         fpu_req;
    fpu_rsp_t         fpu_rsp;
    logic             s_acc;
    logic             out_free;
    logic             r_zero;

    function automatic logic [31:0] canon(input logic [31:0] x);
        if ((x[30:23] == 8'hFF) && (x[22:0] != 23'd0)) return FP_QNAN;
        return x;
    endfunction

    function automatic logic [31:0] opnd_val(input opnd_t c);
        logic [31:0] v;
        case (c)
            OPD_POS0: v = pos_reg[0];
            OPD_POS1: v = pos_reg[1];
            OPD_POS2: v = pos_reg[2];
            OPD_VEL0: v = vel_reg[0];
            OPD_VEL1: v = vel_reg[1];
            OPD_VEL2: v = vel_reg[2];
            OPD_FS0:  v = fs_reg[0];
            OPD_FS1:  v = fs_reg[1];
            OPD_FS2:  v = fs_reg[2];
            OPD_PF0:  v = pf_reg[0];
            OPD_PF1:  v = pf_reg[1];
            OPD_PF2:  v = pf_reg[2];
            OPD_IN0:  v = in_reg[0];
            OPD_IN1:  v = in_reg[1];
            OPD_IN2:  v = in_reg[2];
            OPD_MJ:   v = mj_reg;
            OPD_DT:   v = dt_reg;
            OPD_MASS: v = mass_reg;
            OPD_HALF: v = FP_HALF;
            OPD_D0:   v = d_reg[0];
            OPD_D1:   v = d_reg[1];
            OPD_D2:   v = d_reg[2];
            OPD_R:    v = r_reg;
            OPD_T:    v = t_reg;
            OPD_NUM:  v = num_reg;
            OPD_DEN:  v = den_reg;
            OPD_F:    v = f_reg;
            OPD_A:    v = a_reg;
            default:  v = 32'd0;
        endcase
        return v;
    endfunction

    assign uop           = ucode(pc_reg);
    assign fpu_req.start = (st_reg == S_ISSUE);
    assign fpu_req.op    = uop.op;
    assign fpu_req.a     = opnd_val(uop.src_a);
    assign fpu_req.b     = opnd_val(uop.src_b);

    pgv_fpu u_fpu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (fpu_req),
        .rsp     (fpu_rsp)
    );

    assign s_tready = (st_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign r_zero   = (fpu_rsp.result[30:0] == 31'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= S_IDLE;
            pc_reg      <= PC_FORCE;
            flag_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            mass_reg    <= 32'd0;
            for (int c = 0; c < 3; c++) begin
                pos_reg[c] <= 32'd0;
                vel_reg[c] <= 32'd0;
                fs_reg[c]  <= 32'd0;
                pf_reg[c]  <= 32'd0;
            end
        end else begin
            if (cfg_wen) mass_reg <= cfg_wdata;
            if (m_valid_reg && m_tready && st_reg != S_FINISH) m_valid_reg <= 1'b0;
            case (st_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        act_reg  <= action_t'(s_tuser);
                        flag_reg <= 1'b0;
                        for (int c = 0; c < 3; c++) begin
                            in_reg[c] <= s_tdata[32*c +: 32];
                        end
                        mj_reg <= s_tdata[223:192];
                        dt_reg <= s_tdata[255:224];
                        case (action_t'(s_tuser))
                            ACT_LOAD: begin
                                for (int c = 0; c < 3; c++) begin
                                    pos_reg[c] <= canon(s_tdata[32*c +: 32]);
                                    vel_reg[c] <= canon(s_tdata[96 + 32*c +: 32]);
                                    fs_reg[c]  <= 32'd0;
                                    pf_reg[c]  <= 32'd0;
                                end
                                st_reg <= S_FINISH;
                            end
                            ACT_FORCE: begin
                                pc_reg <= PC_FORCE;
                                st_reg <= S_ISSUE;
                            end
                            ACT_UPD_POS: begin
                                pc_reg <= PC_UPD_POS;
                                st_reg <= S_ISSUE;
                            end
                            default: begin
                                pc_reg <= PC_UPD_VEL;
                                st_reg <= S_ISSUE;
                            end
                        endcase
                    end
                end
                S_ISSUE: st_reg <= S_WAIT;
                S_WAIT: begin
                    if (fpu_rsp.done) begin
                        case (uop.dst)
                            OPD_POS0: pos_reg[0] <= fpu_rsp.result;
                            OPD_POS1: pos_reg[1] <= fpu_rsp.result;
                            OPD_POS2: pos_reg[2] <= fpu_rsp.result;
                            OPD_VEL0: vel_reg[0] <= fpu_rsp.result;
                            OPD_VEL1: vel_reg[1] <= fpu_rsp.result;
                            OPD_VEL2: vel_reg[2] <= fpu_rsp.result;
                            OPD_FS0:  fs_reg[0]  <= fpu_rsp.result;
                            OPD_FS1:  fs_reg[1]  <= fpu_rsp.result;
                            OPD_FS2:  fs_reg[2]  <= fpu_rsp.result;
                            OPD_D0:   d_reg[0]   <= fpu_rsp.result;
                            OPD_D1:   d_reg[1]   <= fpu_rsp.result;
                            OPD_D2:   d_reg[2]   <= fpu_rsp.result;
                            OPD_R:    r_reg      <= fpu_rsp.result;
                            OPD_NUM:  num_reg    <= fpu_rsp.result;
                            OPD_DEN:  den_reg    <= fpu_rsp.result;
                            OPD_F:    f_reg      <= fpu_rsp.result;
                            OPD_A:    a_reg      <= fpu_rsp.result;
                            default:  t_reg      <= fpu_rsp.result;
                        endcase
                        if (uop.zchk && r_zero) begin
                            flag_reg <= 1'b1;
                            st_reg   <= S_FINISH;
                        end else if (uop.last) begin
                            if (act_reg == ACT_UPD_POS) begin
                                for (int c = 0; c < 3; c++) begin
                                    pf_reg[c] <= fs_reg[c];
                                    fs_reg[c] <= 32'd0;
                                end
                            end
                            st_reg <= S_FINISH;
                        end else begin
                            pc_reg <= pc_reg + 6'd1;
                            st_reg <= S_ISSUE;
                        end
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        st_reg      <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
        if (st_reg == S_FINISH && out_free) begin
            m_data_reg <= {fs_reg[2], fs_reg[1], fs_reg[0],
                           vel_reg[2], vel_reg[1], vel_reg[0],
                           pos_reg[2], pos_reg[1], pos_reg[0]};
            m_user_reg <= flag_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

// ===== design/pgv_checker.sv =====
// port level checks for the particle verlet update block, bound to the top
// depends on assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module pgv_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [287:0] m_tdata,
    input wire logic         m_tuser
);

    `PGV_ASSERT_CLK(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `PGV_ASSERT_CLK(a_busy_after_req, aclk, aresetn, s_tvalid && s_tready |=> !s_tready)
    `PGV_ASSERT_ALL(a_reset_empty, aclk, !aresetn |=> !m_tvalid)

endmodule

bind particle_gravity_verlet_update pgv_checker u_pgv_checker (.*);

`default_nettype wire

// ===== dv/tb.sv =====
// testbench for particle_gravity_verlet_update: drives load, force and verlet step requests
// and checks every returned state against a single-precision model of the particle
// depends on pgv_pkg and the particle_gravity_verlet_update rtl
`timescale 1ns / 100ps

module tb;
    import pgv_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [31:0] F_ONE = 32'h3F80_0000;

    typedef struct {
        logic [287:0] state;
        logic         coincident;
    } particle_result_t;

    class verlet_scoreboard;
        logic [31:0] mass;
        logic [31:0] pos[3];
        logic [31:0] vel[3];
        logic [31:0] fsum[3];
        logic [31:0] fprev[3];
        particle_result_t expected_q[$];
        int errors;
        int checked;
        int skipped;

        function void clear();
            mass = '0;
            for (int c = 0; c < 3; c++) begin
                pos[c] = '0;
                vel[c] = '0;
                fsum[c] = '0;
                fprev[c] = '0;
            end
        endfunction

        function real to_r(logic [31:0] b);
            logic [10:0] e;
            real v;
            e = 11'(b[30:23]) + 11'd896;
            if (b[30:23] == 8'hFF) begin
                if (b[22:0] != 0) return $bitstoreal(64'h7FF8_0000_0000_0000);
                return $bitstoreal({b[31], 11'h7FF, 52'd0});
            end
            if (b[30:0] == 0) return $bitstoreal({b[31], 63'd0});
            if (b[30:23] == 0) begin
                v = real'(b[22:0]) * (2.0 ** (-149));
                return b[31] ? -v : v;
            end
            return $bitstoreal({b[31], e, b[22:0], 29'd0});
        endfunction

        // round a double to single, nearest even
        function logic [31:0] to_f(real x);
            logic [63:0] d;
            logic [63:0] mant;
            logic [63:0] q;
            int ex;
            int sh;
            logic rb;
            logic st;
            d = $realtobits(x);
            if (d[62:52] == 11'h7FF) begin
                if (d[51:0] != 0) return FP_QNAN;
                return {d[63], 8'hFF, 23'd0};
            end
            if (d[62:52] == 0) return {d[63], 31'd0};
            ex = int'(d[62:52]) - 1023;
            if (ex > 127) return {d[63], 8'hFF, 23'd0};
            mant = {11'd0, 1'b1, d[51:0]};
            sh = (ex >= -126) ? 29 : 29 + (-126 - ex);
            if (sh >= 60) return {d[63], 31'd0};
            q = mant >> sh;
            rb = mant[sh-1];
            st = (mant & ((64'd1 << (sh - 1)) - 1)) != 0;
            if (rb && (st || q[0])) q++;
            if (ex >= -126) begin
                if (q == 64'd1 << 24) begin
                    q = q >> 1;
                    ex++;
                end
                if (ex > 127) return {d[63], 8'hFF, 23'd0};
                return {d[63], 8'(ex + 127), q[22:0]};
            end
            return {d[63], q[30:0]};
        endfunction

        function logic is_nan(logic [31:0] b);
            return b[30:23] == 8'hFF && b[22:0] != 0;
        endfunction

        function logic [31:0] canon(logic [31:0] b);
            return is_nan(b) ? FP_QNAN : b;
        endfunction

        function logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
            return to_f(to_r(a) + to_r(b));
        endfunction

        function logic [31:0] fsub(logic [31:0] a, logic [31:0] b);
            return to_f(to_r(a) - to_r(b));
        endfunction

        function logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
            return to_f(to_r(a) * to_r(b));
        endfunction

        function logic [31:0] fdiv(logic [31:0] n, logic [31:0] d);
            if (d[30:0] == 0) begin
                if (is_nan(n) || n[30:0] == 0) return FP_QNAN;
                return {n[31] ^ d[31], 8'hFF, 23'd0};
            end
            return to_f(to_r(n) / to_r(d));
        endfunction

        function logic [31:0] fsqrt(logic [31:0] x);
            if (is_nan(x)) return FP_QNAN;
            if (x[31]) return (x[30:0] == 0) ? x : FP_QNAN;
            if (x[30:23] == 8'hFF || x == 0) return x;
            return to_f($sqrt(to_r(x)));
        endfunction

        function void note_request(action_t act, logic [255:0] data);
            logic [31:0] fld[8];
            logic [31:0] d[3];
            logic [31:0] r;
            logic [31:0] f;
            logic [31:0] a;
            logic [31:0] t;
            particle_result_t res;
            for (int i = 0; i < 8; i++) fld[i] = data[32*i +: 32];
            res.coincident = 1'b0;
            case (act)
                ACT_LOAD: begin
                    for (int c = 0; c < 3; c++) begin
                        pos[c] = canon(fld[c]);
                        vel[c] = canon(fld[3+c]);
                        fsum[c] = '0;
                        fprev[c] = '0;
                    end
                end
                ACT_FORCE: begin
                    for (int c = 0; c < 3; c++) d[c] = fsub(fld[c], pos[c]);
                    r = fadd(fmul(d[0], d[0]), fmul(d[1], d[1]));
                    r = fadd(r, fmul(d[2], d[2]));
                    if (r[30:0] == 0) begin
                        res.coincident = 1'b1;
                        skipped++;
                    end else begin
                        f = fdiv(fmul(mass, fld[6]), fmul(fsqrt(r), r));
                        for (int c = 0; c < 3; c++) fsum[c] = canon(fadd(fsum[c], fmul(f, d[c])));
                    end
                end
                default: begin
                    a = fdiv(fmul(fld[7], FP_HALF), mass);
                    for (int c = 0; c < 3; c++) begin
                        if (act == ACT_UPD_POS) begin
                            t = fmul(fld[7], fadd(vel[c], fmul(a, fsum[c])));
                            pos[c] = canon(fadd(pos[c], t));
                            fprev[c] = fsum[c];
                            fsum[c] = '0;
                        end else begin
                            t = fmul(a, fadd(fsum[c], fprev[c]));
                            vel[c] = canon(fadd(vel[c], t));
                        end
                    end
                end
            endcase
            res.state = {fsum[2], fsum[1], fsum[0], vel[2], vel[1], vel[0],
                         pos[2], pos[1], pos[0]};
            expected_q.push_back(res);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic [287:0] state, logic coincident);
            particle_result_t exp_res;
            string names[9] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z",
                                "force_x", "force_y", "force_z"};
            if (expected_q.size() == 0) begin
                report("result with no request outstanding");
                return;
            end
            exp_res = expected_q.pop_front();
            checked++;
            for (int i = 0; i < 9; i++)
                if (state[32*i +: 32] !== exp_res.state[32*i +: 32])
                    report($sformatf("result %0d %s got %h want %h", checked, names[i],
                                     state[32*i +: 32], exp_res.state[32*i +: 32]));
            if (coincident !== exp_res.coincident)
                report($sformatf("result %0d coincident got %b want %b", checked,
                                 coincident, exp_res.coincident));
        endtask
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [255:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [287:0] m_tdata;
    logic         m_tuser;
    logic         cfg_wen = 1'b0;
    logic [31:0]  cfg_wdata = '0;

    verlet_scoreboard sb;
    bit  gaps_on = 1'b1;
    int  stall_left = 0;
    int  cycles = 0;
    int  sent = 0;
    int  phases = 0;

    particle_gravity_verlet_update i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("particle_gravity_verlet_update regression: fail");
            $finish;
        end
    end

    // result side: check on handshake, stall in bursts
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_request(action_t act, logic [31:0] px, logic [31:0] py,
                                logic [31:0] pz, logic [31:0] vx, logic [31:0] vy,
                                logic [31:0] vz, logic [31:0] mj, logic [31:0] dt);
        logic [255:0] data;
        data = {dt, mj, vz, vy, vx, pz, py, px};
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= data;
        s_tuser <= act;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(act, data);
        sent++;
    endtask

    task automatic drain_and_set_mass(logic [31:0] m);
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wen <= 1'b1;
        cfg_wdata <= m;
        @(posedge aclk);
        sb.mass = m;
        cfg_wen <= 1'b0;
        phases++;
    endtask

    function automatic logic [31:0] pick_float();
        logic [31:0] specials[7] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
                                     32'hFF80_0000, 32'h7FC0_0001, 32'h0000_0001,
                                     32'h7F7F_FFFF};
        case ($urandom_range(0, 15))
            0: return $urandom;
            1: return specials[$urandom_range(0, 6)];
            default: return {1'($urandom), 8'($urandom_range(120, 134)), 23'($urandom)};
        endcase
    endfunction

    function automatic logic [31:0] tame_float();
        return {1'($urandom), 8'($urandom_range(122, 132)), 23'($urandom)};
    endfunction

    task automatic send_load();
        send_request(ACT_LOAD, tame_float(), tame_float(), tame_float(), tame_float(),
                     tame_float(), tame_float(), $urandom, $urandom);
    endtask

    task automatic send_force();
        logic [31:0] p[3];
        for (int c = 0; c < 3; c++) p[c] = tame_float();
        // partner sitting on top of the particle now and then
        if ($urandom_range(0, 9) == 0) for (int c = 0; c < 3; c++) p[c] = sb.pos[c];
        send_request(ACT_FORCE, p[0], p[1], p[2], $urandom, $urandom, $urandom,
                     pick_float(), $urandom);
    endtask

    task automatic send_step(action_t act);
        send_request(act, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, {1'b0, 8'($urandom_range(115, 127)), 23'($urandom)});
    endtask

    task automatic send_noise();
        send_request(action_t'($urandom_range(0, 3)), pick_float(), pick_float(),
                     pick_float(), pick_float(), pick_float(), pick_float(), pick_float(),
                     pick_float());
    endtask

    task automatic random_phase(int count);
        int stop_at;
        stop_at = sent + count;
        while (sent < stop_at) begin
            if ($urandom_range(0, 4) == 0) begin
                send_noise();
            end else begin
                send_load();
                repeat ($urandom_range(1, 2)) begin
                    repeat ($urandom_range(1, 4)) send_force();
                    send_step(ACT_UPD_POS);
                    send_step(ACT_UPD_VEL);
                end
            end
        end
    endtask

    initial begin
        logic [31:0] masses[5];
        sb = new();
        sb.clear();
        sb.errors = 0;
        sb.checked = 0;
        sb.skipped = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: a fresh particle, a full round, and the awkward values
        drain_and_set_mass(F_ONE);
        send_request(ACT_LOAD, 32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, '0, '0, '0,
                     '0, '0);
        send_request(ACT_FORCE, 32'h4080_0000, 32'h4000_0000, 32'h4040_0000, '1, '1, '1,
                     32'h4000_0000, '1);
        send_request(ACT_FORCE, 32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, '0, '0, '0,
                     32'h4000_0000, '0);
        send_request(ACT_UPD_POS, '0, '0, '0, '0, '0, '0, '0, 32'h3DCC_CCCD);
        send_request(ACT_UPD_VEL, '0, '0, '0, '0, '0, '0, '0, 32'h3DCC_CCCD);
        send_request(ACT_LOAD, '0, '0, '0, 32'h7F80_0000, 32'hFF80_0000, 32'h7F7F_FFFF,
                     '0, '0);
        // distance whose cube underflows
        send_request(ACT_FORCE, 32'h2680_0000, '0, '0, '0, '0, '0, 32'h3F80_0000, '0);
        send_request(ACT_FORCE, 32'h0000_0001, '0, '0, '0, '0, '0, 32'h3F80_0000, '0);
        send_request(ACT_FORCE, 32'h7F7F_FFFF, 32'hFF7F_FFFF, '0, '0, '0, '0, '1, '0);
        send_request(ACT_UPD_POS, '1, '1, '1, '1, '1, '1, '1, 32'h7F80_0000);
        send_request(ACT_UPD_VEL, '0, '0, '0, '0, '0, '0, '0, '0);
        send_request(ACT_LOAD, 32'hFFFF_FFFF, 32'h7F80_0001, 32'h8000_0000, '1,
                     32'h0000_0001, 32'h807F_FFFF, '0, '0);
        send_request(ACT_UPD_POS, '0, '0, '0, '0, '0, '0, '0, 32'hFFFF_FFFF);
        send_request(ACT_UPD_VEL, '0, '0, '0, '0, '0, '0, '0, 32'h8000_0000);
        send_request(ACT_FORCE, 32'h4000_0000, '0, '0, '0, '0, '0, 32'h7F80_0000, '0);

        masses = '{F_ONE, 32'h0000_0000, 32'h0000_0001, 32'h7F7F_FFFF, 32'hFFFF_FFFF};
        for (int i = 0; i < 5; i++) begin
            drain_and_set_mass(masses[i]);
            send_request(ACT_UPD_VEL, '0, '0, '0, '0, '0, '0, '0, 32'h3F80_0000);
            random_phase(i == 0 ? 250 : 60);
        end
        drain_and_set_mass({1'b0, 8'($urandom_range(124, 130)), 23'($urandom)});
        random_phase(120);
        gaps_on = 1'b0;
        random_phase(80);

        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (250) @(posedge aclk);
        $display("covered %0d requests over %0d mass settings, %0d results checked",
                 sent, phases, sb.checked);
        $display("%0d coincident partners skipped, %0d mismatches", sb.skipped, sb.errors);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("particle_gravity_verlet_update regression: pass");
        else
            $display("particle_gravity_verlet_update regression: fail");
        $finish;
    end

endmodule
